FILE: design/rfdr_pkg.sv
// shared types and constants of the receive frame descriptor ring
package rfdr_pkg;

   localparam int LEN_W     = 11;  // frame length field
   localparam int CAP_W     = 16;  // caller buffer capacity field
   localparam int OUT_IDX_W = 2;   // width of reported count and slot

   typedef enum logic {
      REQ_FRAME_DONE = 1'b0,
      REQ_READ       = 1'b1
   } req_code_type;

   // what the index stage hands to the response stage for one item
   typedef struct packed {
      logic [LEN_W-1:0] delivered;
      logic             read_empty;
      logic             overwrote;
      logic             fwd;       // head slot written by this same item
      logic [LEN_W-1:0] fwd_len;
   } step_info_type;

endpackage

FILE: design/rfdr_ram.sv
// generic single write port, single read port ram with registered read
module rfdr_ram #(
   parameter int WIDTH = 11,
   parameter int DEPTH = 4,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: design/rfdr_ctrl.sv
// fill, drain and count registers of the ring, and the slot store access
module rfdr_ctrl #(
   parameter int QUEUE_DEPTH = 4,
   localparam int IDX_W = $clog2(QUEUE_DEPTH)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  rfdr_pkg::req_code_type       req_type,
   input  logic [rfdr_pkg::LEN_W-1:0]   frame_length,
   input  logic [rfdr_pkg::CAP_W-1:0]   caller_capacity,
   input  logic [rfdr_pkg::LEN_W-1:0]   head_now,
   output logic                         mem_we,
   output logic [IDX_W-1:0]             mem_waddr,
   output logic [rfdr_pkg::LEN_W-1:0]   mem_wdata,
   output logic                         mem_re,
   output logic [IDX_W-1:0]             mem_raddr,
   output rfdr_pkg::step_info_type      info,
   output logic [IDX_W-1:0]             next_count,
   output logic [IDX_W-1:0]             next_fill
);
   import rfdr_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

   logic [IDX_W-1:0] fill_ff, fill_in;
   logic [IDX_W-1:0] drain_ff, drain_in;
   logic [IDX_W-1:0] count_ff, count_in;
   logic             ring_full;
   logic             ring_empty;

   function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
      return (idx == LAST_IDX) ? '0 : idx + 1'b1;
   endfunction

   assign ring_full  = (count_ff == LAST_IDX);
   assign ring_empty = (count_ff == '0);

   always_comb begin
      fill_in  = fill_ff;
      drain_in = drain_ff;
      count_in = count_ff;
      info     = '0;
      mem_we   = 1'b0;
      if (req_type == REQ_FRAME_DONE) begin
         mem_we = accept;
         if (ring_full) begin
            // fill slot is not a waiting frame, just replace it
            info.overwrote = 1'b1;
         end else begin
            count_in = count_ff + 1'b1;
            fill_in  = wrap_inc(fill_ff);
         end
      end else begin
         if (ring_empty) begin
            info.read_empty = 1'b1;
         end else begin
            if (caller_capacity < {{(CAP_W-LEN_W){1'b0}}, head_now}) begin
               info.delivered = caller_capacity[LEN_W-1:0];
            end else begin
               info.delivered = head_now;
            end
            drain_in = wrap_inc(drain_ff);
            count_in = count_ff - 1'b1;
         end
      end
      // new head slot is read on every item; same-slot write is forwarded
      info.fwd     = (req_type == REQ_FRAME_DONE) && (fill_ff == drain_in);
      info.fwd_len = frame_length;
   end

   assign mem_waddr  = fill_ff;
   assign mem_wdata  = frame_length;
   assign mem_re     = accept;
   assign mem_raddr  = drain_in;
   assign next_count = count_in;
   assign next_fill  = fill_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         drain_ff <= '0;
         count_ff <= '0;
      end else if (accept) begin
         fill_ff  <= fill_in;
         drain_ff <= drain_in;
         count_ff <= count_in;
      end
   end

`ifndef SYNTHESIS
   logic [IDX_W:0] ring_sum;
   logic [IDX_W:0] ring_end;
   assign ring_sum = {1'b0, drain_ff} + {1'b0, count_ff};
   assign ring_end = (ring_sum >= (IDX_W+1)'(QUEUE_DEPTH)) ?
                     ring_sum - (IDX_W+1)'(QUEUE_DEPTH) : ring_sum;

   a_ring_position: assert property (@(posedge clock) disable iff (reset)
      {1'b0, fill_ff} == ring_end)
      else $error("fill index does not sit count slots past drain index");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LAST_IDX)
      else $error("waiting count beyond ring capacity");

   a_empty_read_quiet: assert property (@(posedge clock) disable iff (reset)
      accept && (req_type == REQ_READ) && ring_empty |=>
         $stable(drain_ff) && $stable(count_ff) && $stable(fill_ff))
      else $error("read of empty ring changed ring state");
`endif

endmodule

FILE: design/rx_frame_descriptor_ring.sv
// top level of the receive frame descriptor ring
//
// ring of QUEUE_DEPTH receive slots holding frame lengths. a frame-done item
// (req_type 0) stores req_frame_length in the fill slot and advances fill and
// count while fewer than QUEUE_DEPTH-1 frames wait; on a full ring it
// overwrites the fill slot and flags rsp_overwrote_slot. a read item
// (req_type 1) hands out the oldest length clipped to req_caller_capacity and
// advances the drain slot, or reports rsp_read_was_empty. every item gives
// exactly one response carrying the head length, waiting count and fill slot
// after the item. throughput is one item per clock while the response side
// keeps up; an accepted item goes to the head stage, which waits for the slot
// store's registered read of the new head slot, and then to the response
// register. the response register lets one further item enter while a
// finished response waits. the slot store needs no clearing pass after
// reset: only slots holding a waiting frame are ever reported
module rx_frame_descriptor_ring #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_type,
   input  logic [rfdr_pkg::LEN_W-1:0]         req_frame_length,
   input  logic [rfdr_pkg::CAP_W-1:0]         req_caller_capacity,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [rfdr_pkg::LEN_W-1:0]         rsp_delivered_length,
   output logic                               rsp_read_was_empty,
   output logic                               rsp_overwrote_slot,
   output logic [rfdr_pkg::LEN_W-1:0]         rsp_head_length,
   output logic [rfdr_pkg::OUT_IDX_W-1:0]     rsp_frames_waiting,
   output logic [rfdr_pkg::OUT_IDX_W-1:0]     rsp_receive_slot
);
   import rfdr_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);

   // request acceptance
   logic                  req_accept;
   req_code_type          req_code;

   // slot store interface
   logic                  ram_we;
   logic [IDX_W-1:0]      ram_waddr;
   logic [LEN_W-1:0]      ram_wdata;
   logic                  ram_re;
   logic [IDX_W-1:0]      ram_raddr;
   logic [LEN_W-1:0]      ram_rdata;

   // index stage outputs
   step_info_type         step_info;
   logic [IDX_W-1:0]      step_count;
   logic [IDX_W-1:0]      step_fill;

   // head stage: item waiting for its head slot read
   logic                  s2_valid_ff, s2_valid_in;
   step_info_type         s2_info_ff;
   logic [IDX_W-1:0]      s2_count_ff;
   logic [IDX_W-1:0]      s2_fill_ff;
   logic                  s2_move;
   logic [LEN_W-1:0]      s2_head_raw;
   logic [LEN_W-1:0]      s2_head;

   // current head length as seen by the next item
   logic [LEN_W-1:0]      head_ff;
   logic [LEN_W-1:0]      head_now;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [LEN_W-1:0]      rsp_delivered_ff;
   logic                  rsp_empty_ff;
   logic                  rsp_overwrote_ff;
   logic [LEN_W-1:0]      rsp_head_ff;
   logic [OUT_IDX_W-1:0]  rsp_count_ff;
   logic [OUT_IDX_W-1:0]  rsp_fill_ff;

   // head stage advances whenever the response register is free or draining
   assign s2_move    = s2_valid_ff && (!rsp_valid_ff || !rsp_stall);
   // stall during reset and while the head stage is stuck; the ram read data then holds
   assign req_stall  = reset || (s2_valid_ff && !s2_move);
   assign req_accept = req_valid && !req_stall;
   assign req_code   = req_code_type'(req_type);

   rfdr_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .accept          (req_accept),
      .req_type        (req_code),
      .frame_length    (req_frame_length),
      .caller_capacity (req_caller_capacity),
      .head_now        (head_now),
      .mem_we          (ram_we),
      .mem_waddr       (ram_waddr),
      .mem_wdata       (ram_wdata),
      .mem_re          (ram_re),
      .mem_raddr       (ram_raddr),
      .info            (step_info),
      .next_count      (step_count),
      .next_fill       (step_fill)
   );

   rfdr_ram #(
      .WIDTH (LEN_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_slot_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // head slot value: forwarded when this item wrote the head slot itself
   assign s2_head_raw = s2_info_ff.fwd ? s2_info_ff.fwd_len : ram_rdata;
   assign s2_head     = (s2_count_ff == '0) ? '0 : s2_head_raw;
   // an item in the head stage already holds the newest head length
   assign head_now    = s2_valid_ff ? s2_head : head_ff;

   assign s2_valid_in  = req_accept || (s2_valid_ff && !s2_move);
   assign rsp_valid_in = s2_move || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      // payload, no reset needed
      if (req_accept) begin
         s2_info_ff  <= step_info;
         s2_count_ff <= step_count;
         s2_fill_ff  <= step_fill;
      end
      if (s2_move) begin
         head_ff          <= s2_head;
         rsp_delivered_ff <= s2_info_ff.delivered;
         rsp_empty_ff     <= s2_info_ff.read_empty;
         rsp_overwrote_ff <= s2_info_ff.overwrote;
         rsp_head_ff      <= s2_head;
         rsp_count_ff     <= OUT_IDX_W'(s2_count_ff);
         rsp_fill_ff      <= OUT_IDX_W'(s2_fill_ff);
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_delivered_length = rsp_delivered_ff;
   assign rsp_read_was_empty   = rsp_empty_ff;
   assign rsp_overwrote_slot   = rsp_overwrote_ff;
   assign rsp_head_length      = rsp_head_ff;
   assign rsp_frames_waiting   = rsp_count_ff;
   assign rsp_receive_slot     = rsp_fill_ff;

`ifndef SYNTHESIS
   a_item_reaches_head_stage: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s2_valid_ff)
      else $error("accepted item did not enter head stage");

   a_head_read_holds: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !s2_move |=> $stable(ram_rdata))
      else $error("head slot read data changed while item held");

   a_one_flag_per_kind: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> !(s2_info_ff.read_empty && s2_info_ff.overwrote))
      else $error("item flagged both empty read and overwrite");
`endif

endmodule
